// ===== rtl/rgc_pkg.sv =====
`timescale 1ns / 1ps

package rgc_pkg;

    // field widths fixed by the interface
    localparam int CH_W      = 8;
    localparam int GRADE_W   = 28;
    localparam int CNT_OUT_W = 16;

    // default counter width
    localparam int COUNT_WIDTH_DEF = 16;

    // grade constants, Q.8: 0.39, 11.8 and 15.59 times 256
    localparam int MUL_EXT_W    = 12;
    localparam int WORD_MUL     = 100;
    localparam int SYL_MUL      = 3021;
    localparam int GRADE_OFFSET = 3991;
    localparam int GRADE_MAX    = 134217727;

    // character codes
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_CASE  = 8'h20;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic load_prod;
        logic div_start;
        logic div_sel;
        logic load_q1;
        logic load_sum;
        logic load_out;
    } rgc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic zero;
        logic div_done;
        logic out_free;
    } rgc_sts_t;

endpackage

// ===== rtl/rgc_div.sv =====
`timescale 1ns / 1ps

module rgc_div #(
    parameter int COUNT_WIDTH = rgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [COUNT_WIDTH+rgc_pkg::MUL_EXT_W-1:0] dividend,
    input  logic [COUNT_WIDTH-1:0]                    divisor,
    output logic                                      done,
    output logic [COUNT_WIDTH+rgc_pkg::MUL_EXT_W-1:0] quotient
);
    import rgc_pkg::*;

    localparam int NW = COUNT_WIDTH + MUL_EXT_W;
    localparam int CW = $clog2(NW + 1);

    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] div_reg, div_next;
    logic [NW-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic [COUNT_WIDTH:0]   rem_sub;
    logic                   ge;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // partial remainder stays below a nonzero divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/rgc_dp.sv =====
`timescale 1ns / 1ps

module rgc_dp #(
    parameter int COUNT_WIDTH = rgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  text_valid,
    input  logic [rgc_pkg::CH_W-1:0]              ch,
    input  logic                                  last,
    input  logic                                  result_stall,
    input  rgc_pkg::rgc_cmd_t                     cmd,
    output rgc_pkg::rgc_sts_t                     sts,
    output logic                                  result_valid,
    output logic signed [rgc_pkg::GRADE_W-1:0]    grade,
    output logic [rgc_pkg::CNT_OUT_W-1:0]         sentence_count,
    output logic [rgc_pkg::CNT_OUT_W-1:0]         word_count,
    output logic [rgc_pkg::CNT_OUT_W-1:0]         syllable_count,
    output logic                                  saturated
);
    import rgc_pkg::*;

    localparam int NW = COUNT_WIDTH + MUL_EXT_W;
    localparam int SW = NW + 1;
    localparam int XW = (SW > GRADE_W) ? SW : GRADE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] sent_reg, sent_next;
    logic [COUNT_WIDTH-1:0] word_reg, word_next;
    logic [COUNT_WIDTH-1:0] syl_reg, syl_next;
    logic                   vowel_reg, vowel_next;
    logic                   letter_reg, letter_next;
    logic                   ovf_reg, ovf_next;

    logic                   take;
    logic                   is_space, is_vowel, is_letter, is_punct;
    logic [CH_W-1:0]        lc;
    logic                   sent_bump, word_bump, syl_bump;

    logic [NW-1:0]          prod_w_reg, prod_y_reg;
    logic [NW-1:0]          q1_reg;
    logic [SW-1:0]          sum_reg;
    logic [NW-1:0]          div_dividend, div_quo;
    logic [COUNT_WIDTH-1:0] div_divisor;
    logic                   div_done;

    logic [XW-1:0]          sum_x, diff_x;
    logic [GRADE_W-1:0]     grade_calc;

    logic                   out_valid_reg, out_valid_next;
    logic [GRADE_W-1:0]     grade_reg;
    logic [CNT_OUT_W-1:0]   sent_out_reg, word_out_reg, syl_out_reg;
    logic                   sat_out_reg;
    logic [COUNT_WIDTH+CNT_OUT_W-1:0] sent_ext, word_ext, syl_ext;

    // byte classification
    always_comb
    begin
        take      = text_valid && cmd.take;
        lc        = ch | CH_CASE;
        is_space  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        is_vowel  = (lc == 8'h61) || (lc == 8'h65) || (lc == 8'h69)
                 || (lc == 8'h6F) || (lc == 8'h75);
        is_letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
        is_punct  = (ch == CH_BANG) || (ch == CH_DOT) || (ch == CH_QUEST);
        sent_bump = take && is_punct;
        syl_bump  = take && !is_space && is_vowel && !vowel_reg;
        word_bump = take && (is_space || last)
                 && (letter_reg || (!is_space && is_letter));
    end

    // saturating counters and token state
    always_comb
    begin
        sent_next   = sent_reg;
        word_next   = word_reg;
        syl_next    = syl_reg;
        vowel_next  = vowel_reg;
        letter_next = letter_reg;
        ovf_next    = ovf_reg;
        if (sent_bump)
        begin
            if (sent_reg != CNT_MAX) sent_next = sent_reg + 1'b1;
            if (sent_reg >= CNT_MAX - 1'b1) ovf_next = 1'b1;
        end
        if (word_bump)
        begin
            if (word_reg != CNT_MAX) word_next = word_reg + 1'b1;
            if (word_reg >= CNT_MAX - 1'b1) ovf_next = 1'b1;
        end
        if (syl_bump)
        begin
            if (syl_reg != CNT_MAX) syl_next = syl_reg + 1'b1;
            if (syl_reg >= CNT_MAX - 1'b1) ovf_next = 1'b1;
        end
        if (take)
        begin
            if (is_space || last)
            begin
                vowel_next  = 1'b0;
                letter_next = 1'b0;
            end
            else
            begin
                vowel_next  = is_vowel;
                letter_next = letter_reg || is_letter;
            end
        end
        if (cmd.load_out)
        begin
            sent_next   = '0;
            word_next   = '0;
            syl_next    = '0;
            vowel_next  = 1'b0;
            letter_next = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg   <= '0;
            word_reg   <= '0;
            syl_reg    <= '0;
            vowel_reg  <= 1'b0;
            letter_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            sent_reg   <= sent_next;
            word_reg   <= word_next;
            syl_reg    <= syl_next;
            vowel_reg  <= vowel_next;
            letter_reg <= letter_next;
            ovf_reg    <= ovf_next;
        end
    end

    // scaled numerators, quotient and sum
    always_ff @(posedge clk)
    begin
        if (cmd.load_prod)
        begin
            prod_w_reg <= NW'(word_reg) * NW'(WORD_MUL);
            prod_y_reg <= NW'(syl_reg) * NW'(SYL_MUL);
        end
        if (cmd.load_q1)
        begin
            q1_reg <= div_quo;
        end
        if (cmd.load_sum)
        begin
            sum_reg <= SW'(q1_reg) + SW'(div_quo);
        end
    end

    // shared divider
    assign div_dividend = cmd.div_sel ? prod_y_reg : prod_w_reg;
    assign div_divisor  = cmd.div_sel ? word_reg : sent_reg;

    rgc_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    // offset and clamp
    always_comb
    begin
        sum_x  = XW'(sum_reg);
        diff_x = sum_x - XW'(GRADE_OFFSET);
        if (sts.zero)
            grade_calc = '0;
        else if (sum_x >= XW'(GRADE_OFFSET) && diff_x > XW'(GRADE_MAX))
            grade_calc = GRADE_W'(GRADE_MAX);
        else
            grade_calc = diff_x[GRADE_W-1:0];
    end

    assign sent_ext = {{CNT_OUT_W{1'b0}}, sent_reg};
    assign word_ext = {{CNT_OUT_W{1'b0}}, word_reg};
    assign syl_ext  = {{CNT_OUT_W{1'b0}}, syl_reg};

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            grade_reg    <= grade_calc;
            sent_out_reg <= sent_ext[CNT_OUT_W-1:0];
            word_out_reg <= word_ext[CNT_OUT_W-1:0];
            syl_out_reg  <= syl_ext[CNT_OUT_W-1:0];
            sat_out_reg  <= ovf_reg;
        end
    end

    // status to controller
    assign sts.zero     = (sent_reg == '0) || (word_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result_valid   = out_valid_reg;
    assign grade          = grade_reg;
    assign sentence_count = sent_out_reg;
    assign word_count     = word_out_reg;
    assign syllable_count = syl_out_reg;
    assign saturated      = sat_out_reg;

    // counts start over once a result is loaded
    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (sent_reg == '0 && word_reg == '0 && syl_reg == '0
                          && !ovf_reg && !letter_reg))
        else $error("counters not cleared after result load");

endmodule

// ===== rtl/rgc_ctrl.sv =====
`timescale 1ns / 1ps

module rgc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    input  logic               last,
    input  rgc_pkg::rgc_sts_t  sts,
    output rgc_pkg::rgc_cmd_t  cmd,
    output logic               text_stall
);
    import rgc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_D1S  = 3'd2;
    localparam logic [2:0] S_D1W  = 3'd3;
    localparam logic [2:0] S_D2S  = 3'd4;
    localparam logic [2:0] S_D2W  = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    // sequencing of the final transaction
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (text_valid && last)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = sts.zero ? S_DONE : S_D1S;
            end
            S_D1S:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_D1W;
            end
            S_D1W:
            begin
                if (sts.div_done)
                begin
                    cmd.load_q1 = 1'b1;
                    state_next  = S_D2S;
                end
            end
            S_D2S:
            begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_D2W;
            end
            S_D2W:
            begin
                cmd.div_sel = 1'b1;
                if (sts.div_done)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign text_stall = !cmd.take;

    // result only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending one");

    // no division when a divisor is zero
    a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.zero)
        else $error("division started with zero divisor");

    // bytes are never taken while a grade is being worked out
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_prod || cmd.div_start || cmd.load_sum) |-> text_stall)
        else $error("input taken during grade computation");

endmodule

// ===== rtl/readability_grade_counter_top.sv =====
`timescale 1ns / 1ps

// non-final text bytes: one transaction per cycle, no result
// final byte: result valid once two quotients are done on one shared divider
//   that retires one bit per cycle
// final byte of a text with no sentence or no word: no division, grade of zero
// text input stalls from the final byte until the result is loaded
// reset clears all counters, token state and the result valid flag
module readability_grade_counter_top #(
    parameter int COUNT_WIDTH = rgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    output logic                                text_stall,
    input  logic [rgc_pkg::CH_W-1:0]            ch,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [rgc_pkg::GRADE_W-1:0]  grade,
    output logic [rgc_pkg::CNT_OUT_W-1:0]       sentence_count,
    output logic [rgc_pkg::CNT_OUT_W-1:0]       word_count,
    output logic [rgc_pkg::CNT_OUT_W-1:0]       syllable_count,
    output logic                                saturated
);
    import rgc_pkg::*;

    rgc_cmd_t cmd;
    rgc_sts_t sts;

    // control
    rgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_valid(text_valid),
        .last      (last),
        .sts       (sts),
        .cmd       (cmd),
        .text_stall(text_stall)
    );

    // counters, divider and result register
    rgc_dp #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .ch            (ch),
        .last          (last),
        .result_stall  (result_stall),
        .cmd           (cmd),
        .sts           (sts),
        .result_valid  (result_valid),
        .grade         (grade),
        .sentence_count(sentence_count),
        .word_count    (word_count),
        .syllable_count(syllable_count),
        .saturated     (saturated)
    );

endmodule

// ===== verif/readability_grade_checker.sv =====
`timescale 1ns / 1ps

module readability_grade_checker #(
    parameter int COUNT_WIDTH = rgc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    input  logic                                text_stall,
    input  logic [rgc_pkg::CH_W-1:0]            ch,
    input  logic                                last,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic signed [rgc_pkg::GRADE_W-1:0]  grade,
    input  logic [rgc_pkg::CNT_OUT_W-1:0]       sentence_count,
    input  logic [rgc_pkg::CNT_OUT_W-1:0]       word_count,
    input  logic [rgc_pkg::CNT_OUT_W-1:0]       syllable_count,
    input  logic                                saturated,
    output int                                  errors,
    output int                                  pending
);

    import rgc_pkg::*;

    // keep the log short when the block is badly broken
    localparam int PRINT_CAP = 60;

    typedef struct {
        logic signed [GRADE_W-1:0] grade_q8;
        logic [CNT_OUT_W-1:0]      sentences;
        logic [CNT_OUT_W-1:0]      words;
        logic [CNT_OUT_W-1:0]      syllables;
        logic                      sat;
    } text_summary_t;

    text_summary_t summary_q[$];

    // running text statistics
    logic [COUNT_WIDTH-1:0] n_sent;
    logic [COUNT_WIDTH-1:0] n_words;
    logic [COUNT_WIDTH-1:0] n_syl;
    logic                   in_vowel_run;
    logic                   token_lettered;
    logic                   any_saturated;

    initial errors = 0;
    initial pending = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_stats();
        n_sent         = '0;
        n_words        = '0;
        n_syl          = '0;
        in_vowel_run   = 1'b0;
        token_lettered = 1'b0;
        any_saturated  = 1'b0;
    endtask

    // saturating increment, flags when the top is reached
    function automatic logic [COUNT_WIDTH-1:0] bumped(input logic [COUNT_WIDTH-1:0] c);
        if (c != '1)
            c = c + 1'b1;
        if (c == '1)
            any_saturated = 1'b1;
        return c;
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_vowel(input logic [CH_W-1:0] b);
        logic [CH_W-1:0] low;
        low = b | CH_CASE;
        return low == "a" || low == "e" || low == "i" || low == "o" || low == "u";
    endfunction

    function automatic logic is_letter(input logic [CH_W-1:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    task automatic close_token();
        if (token_lettered)
            n_words = bumped(n_words);
        token_lettered = 1'b0;
        in_vowel_run   = 1'b0;
    endtask

    // grade in Q.8 from the current counts
    function automatic logic signed [GRADE_W-1:0] grade_of_text();
        longint unsigned s;
        longint unsigned w;
        longint unsigned y;
        longint unsigned total;
        s = n_sent;
        w = n_words;
        y = n_syl;
        if (s == 0 || w == 0)
            return '0;
        total = (longint'(WORD_MUL) * w) / s + (longint'(SYL_MUL) * y) / w;
        if (total >= longint'(GRADE_OFFSET))
        begin
            total = total - longint'(GRADE_OFFSET);
            if (total > longint'(GRADE_MAX))
                total = longint'(GRADE_MAX);
            return GRADE_W'(total);
        end
        return -GRADE_W'(longint'(GRADE_OFFSET) - total);
    endfunction

    // compare results, then fold each accepted byte into the statistics
    always @(posedge clk or negedge rst_n)
    begin
        text_summary_t want;
        logic [CH_W-1:0] b;
        if (!rst_n)
        begin
            clear_stats();
            summary_q.delete();
        end
        else
        begin
            // result transaction
            if (result_valid && !result_stall)
            begin
                if (summary_q.size() == 0)
                    report_mismatch("unexpected result, grade", grade, 0);
                else
                begin
                    want = summary_q.pop_front();
                    if (grade !== want.grade_q8)
                        report_mismatch("grade", grade, want.grade_q8);
                    if (sentence_count !== want.sentences)
                        report_mismatch("sentence_count", sentence_count, want.sentences);
                    if (word_count !== want.words)
                        report_mismatch("word_count", word_count, want.words);
                    if (syllable_count !== want.syllables)
                        report_mismatch("syllable_count", syllable_count, want.syllables);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end

            // text transaction
            if (text_valid && !text_stall)
            begin
                b = ch;
                if (b == CH_BANG || b == CH_DOT || b == CH_QUEST)
                    n_sent = bumped(n_sent);
                if (is_blank(b))
                    close_token();
                else
                begin
                    if (is_vowel(b))
                    begin
                        if (!in_vowel_run)
                            n_syl = bumped(n_syl);
                        in_vowel_run = 1'b1;
                    end
                    else
                        in_vowel_run = 1'b0;
                    if (is_letter(b))
                        token_lettered = 1'b1;
                end
                if (last)
                begin
                    close_token();
                    want.grade_q8  = grade_of_text();
                    want.sentences = CNT_OUT_W'(n_sent);
                    want.words     = CNT_OUT_W'(n_words);
                    want.syllables = CNT_OUT_W'(n_syl);
                    want.sat       = any_saturated;
                    summary_q.push_back(want);
                    clear_stats();
                end
            end
        end
        pending = summary_q.size();
    end

endmodule

// ===== verif/tb_readability_grade_counter_top.sv =====
`timescale 1ns / 1ps

module tb_readability_grade_counter_top;

    import rgc_pkg::*;

    localparam int COUNT_WIDTH      = COUNT_WIDTH_DEF;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int DRAIN_CYCLES     = 2 * COUNT_WIDTH + 32 + 64;
    localparam int LIMIT_CYCLES     = 2000000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        text_valid;
    logic                        text_stall;
    logic [CH_W-1:0]             ch;
    logic                        last;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [GRADE_W-1:0]   grade;
    logic [CNT_OUT_W-1:0]        sentence_count;
    logic [CNT_OUT_W-1:0]        word_count;
    logic [CNT_OUT_W-1:0]        syllable_count;
    logic                        saturated;

    int errors;
    int pending;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    logic [CH_W-1:0] text_buf[$];

    readability_grade_counter_top #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .ch(ch),
        .last(last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .grade(grade),
        .sentence_count(sentence_count),
        .word_count(word_count),
        .syllable_count(syllable_count),
        .saturated(saturated)
    );

    readability_grade_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .ch(ch),
        .last(last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .grade(grade),
        .sentence_count(sentence_count),
        .word_count(word_count),
        .syllable_count(syllable_count),
        .saturated(saturated),
        .errors(errors),
        .pending(pending)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
        result_stall <= (recv_stall_pct > 0) && (int'($urandom_range(99)) < recv_stall_pct);

    // one text byte transaction, with random gaps ahead of it
    task automatic send_byte(input logic [CH_W-1:0] b, input logic l);
        logic taken;
        while (int'($urandom_range(99)) < send_gap_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        ch         <= b;
        last       <= l;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !text_stall;
            @(posedge clk);
        end
    endtask

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // send the buffered bytes as one text
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // hold the sender until every summary has come back
    task automatic wait_drained();
        text_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // byte mix weighted toward letters, vowels and separators
    function automatic logic [CH_W-1:0] random_text_byte();
        int roll;
        int k;
        string vowels;
        vowels = "aeiouAEIOU";
        roll = $urandom_range(99);
        if (roll < 25)
            return CH_W'("a") + CH_W'($urandom_range(25));
        else if (roll < 45)
            return vowels[$urandom_range(9)];
        else if (roll < 55)
            return CH_W'("A") + CH_W'($urandom_range(25));
        else if (roll < 70)
        begin
            k = $urandom_range(5);
            return (k == 5) ? CH_SPACE : CH_TAB + CH_W'(k);
        end
        else if (roll < 80)
        begin
            k = $urandom_range(2);
            return (k == 0) ? CH_BANG : (k == 1) ? CH_DOT : CH_QUEST;
        end
        else if (roll < 88)
            return 8'h80 + CH_W'($urandom_range(127));
        return CH_W'($urandom_range(255));
    endfunction

    task automatic directed_texts();
        // a word but no sentence, then a sentence but no word
        append_str("a");
        send_text();
        append_str(".");
        send_text();
        // byte extremes
        text_buf.push_back(8'h00);
        send_text();
        text_buf.push_back(8'hFF);
        send_text();
        // high byte splits a vowel run inside one token
        append_str("Ao");
        text_buf.push_back(8'h80);
        append_str("e!");
        send_text();
        // punctuation inside a token breaks the vowel run
        append_str("a.a");
        send_text();
        // every whitespace byte ends a token; vowels open each new token
        for (int c = CH_TAB; c <= CH_CR; c++)
        begin
            append_str("o");
            text_buf.push_back(CH_W'(c));
        end
        append_str("o o");
        send_text();
    endtask

    task automatic random_texts();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_PER_PHASE)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
                send_byte(random_text_byte(), i == len - 1);
            sent += len;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        text_valid <= 1'b0;
        ch         <= '0;
        last       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_gap_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase
            if (phase == 0)
                directed_texts();
            random_texts();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
